FILE: sv/gae_pkg.sv
package gae_pkg;

  localparam int GROUP_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 64;
  localparam int COUNT_W  = 32;

  typedef enum logic [1:0] {
    MODE_SUM  = 2'd0,
    MODE_MEAN = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_MAX  = 2'd3
  } agg_mode_t;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_MISSING = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_WIDE    = 2'd3
  } res_status_t;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [0:0] CFG_MODE = 1'b0;
  localparam logic [0:0] CFG_SKIP = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [GROUP_W-1:0]        group_index;
    logic signed [VALUE_W-1:0] item_value;
    logic                      item_missing;
  } in_item_t;

  typedef struct packed {
    logic [GROUP_W-1:0]         result_group;
    logic signed [RESULT_W-1:0] result_value;
    logic [1:0]                 result_status;
  } out_item_t;

  // One group record as held in the table
  typedef struct packed {
    logic signed [RESULT_W-1:0] acc;
    logic [COUNT_W-1:0]         item_cnt;
    logic [COUNT_W-1:0]         pres_cnt;
    logic                       seen;
    logic                       miss;
  } rec_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_UPD,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic write_back;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

FILE: sv/gae_datapath.sv
module gae_datapath import gae_pkg::*; #(
  parameter int NUM_GROUPS         = 1024,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  item,
  input  agg_mode_t mode,
  input  logic      skip,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t result
);

  localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int RW = $bits(rec_t);
  localparam int NW = RESULT_W + MEAN_FRACTION_BITS;
  localparam int IW = $clog2(NW + 1);

  logic [RW-1:0] mem [NUM_GROUPS];
  rec_t          rd_r;
  in_item_t      it_r;
  logic [AW:0]   clr_r;
  logic          in_rng;

  assign in_rng = ({{(32-GROUP_W){1'b0}}, it_r.group_index} < 32'(NUM_GROUPS));

  // Clear sweep and record read/write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  rec_t nrec;
  logic [AW-1:0] waddr;
  assign waddr = cmd.clr_step ? clr_r[AW-1:0] : it_r.group_index[AW-1:0];

  // Read the record of the held item, so a new offer on the input cannot disturb it
  always_ff @(posedge clk) begin
    if (cmd.clr_step || (cmd.write_back && in_rng)) begin
      mem[waddr] <= cmd.clr_step ? '0 : nrec;
    end
    rd_r <= mem[it_r.group_index[AW-1:0]];
    if (cmd.capture) begin
      it_r <= item;
    end
  end

  assign sts.clr_done = (clr_r == (AW+1)'(NUM_GROUPS-1)) && cmd.clr_step;
  assign sts.is_read  = (it_r.op == OP_READ);

  // Accumulate update, or clear the record on a read
  logic signed [RESULT_W-1:0] v64, sum;
  logic                       ovf;
  logic                       take;
  always_comb begin
    v64  = RESULT_W'(it_r.item_value);
    sum  = rd_r.acc + v64;
    ovf  = (rd_r.acc[RESULT_W-1] == v64[RESULT_W-1]) &&
           (sum[RESULT_W-1] != rd_r.acc[RESULT_W-1]);
    take = !rd_r.seen || ((mode == MODE_MIN) ? (v64 < rd_r.acc) : (v64 > rd_r.acc));
    nrec = rd_r;
    if (it_r.op == OP_READ) begin
      nrec = '0;
    end else begin
      if (rd_r.item_cnt != '1) nrec.item_cnt = rd_r.item_cnt + 1'b1;
      if (it_r.item_missing) begin
        nrec.miss = 1'b1;
      end else begin
        if (rd_r.pres_cnt != '1) nrec.pres_cnt = rd_r.pres_cnt + 1'b1;
        if (mode == MODE_SUM || mode == MODE_MEAN) begin
          nrec.acc = ovf ? (rd_r.acc[RESULT_W-1] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                                 : {1'b0, {(RESULT_W-1){1'b1}}})
                         : sum;
        end else if (take) begin
          nrec.acc = v64;
        end
        nrec.seen = 1'b1;
      end
    end
  end

  // Read result selection
  logic [COUNT_W-1:0] dvs;
  res_status_t        st;
  logic               need;
  always_comb begin
    dvs  = skip ? rd_r.pres_cnt : rd_r.item_cnt;
    st   = ST_VALID;
    need = 1'b0;
    if (!in_rng) begin
      st = ST_EMPTY;
    end else if (!skip && rd_r.miss) begin
      st = ST_MISSING;
    end else begin
      unique case (mode)
        MODE_SUM: begin
          if (rd_r.acc > 64'sd2147483647 || rd_r.acc < -64'sd2147483648) st = ST_WIDE;
        end
        MODE_MEAN: begin
          if (rd_r.pres_cnt == '0 || dvs == '0) st = ST_EMPTY;
          else need = 1'b1;
        end
        default: begin
          if (!rd_r.seen) st = ST_EMPTY;
        end
      endcase
    end
  end
  assign sts.need_div = need;

  // Restoring divider, one quotient bit a cycle
  logic [NW-1:0]      num_r, q_r;
  logic [COUNT_W:0]   rem_r;
  logic [COUNT_W-1:0] d_r;
  logic [IW-1:0]      cnt_r;
  logic               neg_r;
  logic [RESULT_W-1:0] mag;
  logic [COUNT_W:0]   trial;
  logic               ge;

  assign mag   = rd_r.acc[RESULT_W-1] ? (RESULT_W'(0) - rd_r.acc) : rd_r.acc;
  assign trial = {rem_r[COUNT_W-1:0], num_r[NW-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= {mag, {MEAN_FRACTION_BITS{1'b0}}};
      q_r   <= '0;
      rem_r <= '0;
      d_r   <= dvs;
      neg_r <= rd_r.acc[RESULT_W-1];
      cnt_r <= '0;
    end else if (!sts.div_done) begin
      num_r <= num_r << 1;
      rem_r <= ge ? (trial - {1'b0, d_r}) : trial;
      q_r   <= {q_r[NW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end
  assign sts.div_done = (cnt_r == IW'(NW));

  // Saturate the quotient to 64-bit signed
  logic [NW:0]                qx;
  logic signed [RESULT_W-1:0] mean_v;
  always_comb begin
    qx = {1'b0, q_r};
    if (neg_r) begin
      mean_v = (qx >= ((NW+1)'(1) << (RESULT_W-1))) ? {1'b1, {(RESULT_W-1){1'b0}}}
                                                    : RESULT_W'(-qx);
    end else begin
      mean_v = (qx > (((NW+1)'(1) << (RESULT_W-1)) - 1'b1)) ? {1'b0, {(RESULT_W-1){1'b1}}}
                                                             : RESULT_W'(qx);
    end
  end

  // Load the result register on reads only; an accumulate must not touch a waiting result
  always_ff @(posedge clk) begin
    if (cmd.write_back && (it_r.op == OP_READ)) begin
      result.result_group  <= it_r.group_index;
      result.result_status <= st;
      result.result_value  <= (st == ST_VALID || st == ST_WIDE) ? rd_r.acc : '0;
    end else if (cmd.out_load) begin
      result.result_value  <= mean_v;
    end
  end

endmodule

FILE: sv/gae_ctrl.sv
module gae_ctrl import gae_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = 1'b1;
        if (in_valid) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        if (sts.is_read && ov_nxt) begin
          state_nxt = S_UPD;
        end else begin
          cmd.write_back = 1'b1;
          if (sts.is_read && sts.need_div) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            ov_nxt    = ov_nxt || sts.is_read;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/grouped_aggregate_engine_top.sv
// Grouped aggregate engine: per-group sum, mean, min or max.
// Input channel in_valid/in_stall/in_item: op 0 accumulates a value into a
// group record, op 1 reads the group's result and clears the record.
// Result channel out_valid/out_stall/out_item carries one item per read.
// Configuration cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 is the
// aggregate mode, index 1 the skip-missing flag; write only while idle.
// The engine takes a new item only after the last one is through (table
// read, update, write back of the record memory). A mean read also runs
// the bit-serial divider over RESULT_W + MEAN_FRACTION_BITS quotient bits.
// Reset: a clearing pass writes every record to zero, with in_stall high
// throughout.
// When the receiver stalls, the result register holds; accumulates go on,
// and the next read waits in the update stage until the result is taken.
module grouped_aggregate_engine_top import gae_pkg::*; #(
  parameter int NUM_GROUPS         = 1024,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  agg_mode_t mode_r;
  logic      skip_r;
  cmd_t      cmd;
  sts_t      sts;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SUM;
      skip_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= agg_mode_t'(cfg_data[1:0]);
        CFG_SKIP: skip_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gae_datapath #(
    .NUM_GROUPS         (NUM_GROUPS),
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_item),
    .mode   (mode_r),
    .skip   (skip_r),
    .cmd    (cmd),
    .sts    (sts),
    .result (out_item)
  );

endmodule

FILE: sv/gae_checker.sv
module gae_checker import gae_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  a_no_result_for_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.op == OP_ACC && !out_valid |=> ##2 !out_valid)
    else $error("result from accumulate");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("activity after reset");

endmodule

bind grouped_aggregate_engine_top gae_checker u_chk (.*);

FILE: sim/tb_top.sv
module tb_top;
  import gae_pkg::*;

  localparam int NGROUPS    = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int DRAIN_WAIT = 100;    // beyond the mean-read latency
  localparam int STALL_LIMIT = 20000; // cycles with no handshake at all

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  grouped_aggregate_engine_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the group table and the registers
  logic signed [63:0] grp_acc [NGROUPS];
  logic [31:0]        grp_items [NGROUPS];
  logic [31:0]        grp_present [NGROUPS];
  logic               grp_seen [NGROUPS];
  logic               grp_miss [NGROUPS];
  agg_mode_t          cur_mode = MODE_SUM;
  logic               cur_skip = 1'b0;

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        n_acc = 0, n_read = 0, n_checked = 0, n_cfg = 0;
  int        snd_idle = 0, rcv_idle = 0;
  int        quiet_cycles = 0;

  function automatic logic [31:0] inc_sat(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [31:0] v);
    logic signed [64:0] s;
    s = {a[63], a} + {{33{v[31]}}, v};
    if (s[64] != s[63])
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // sum * 2^F / divisor, truncated toward zero, saturated
  function automatic logic signed [63:0] mean_fixed(logic signed [63:0] s,
                                                    logic [31:0] d);
    logic        neg;
    logic [63:0] mag, q, r, m;
    neg = s[63];
    mag = neg ? (64'd0 - s) : s;
    q = mag / d;
    r = mag % d;
    if (q > ({64{1'b1}} >> FRAC_BITS)) return neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    m = (q << FRAC_BITS) + ((r << FRAC_BITS) / d);
    if (neg) return (m[63]) ? {1'b1, 63'd0} : -m;
    return m[63] ? {1'b0, {63{1'b1}}} : m;
  endfunction

  task automatic wipe_group(int g);
    grp_acc[g] = '0; grp_items[g] = '0; grp_present[g] = '0;
    grp_seen[g] = 1'b0; grp_miss[g] = 1'b0;
  endtask

  // Apply one accepted item to the shadow table; queue the result of a read
  task automatic predict_aggregate(in_item_t it);
    int          g;
    out_item_t   r;
    logic [31:0] div;
    g = it.group_index;
    if (it.op == OP_ACC) begin
      n_acc++;
      grp_items[g] = inc_sat(grp_items[g]);
      if (it.item_missing) begin
        grp_miss[g] = 1'b1;
        return;
      end
      grp_present[g] = inc_sat(grp_present[g]);
      if (cur_mode == MODE_SUM || cur_mode == MODE_MEAN)
        grp_acc[g] = add_sat(grp_acc[g], it.item_value);
      else if (!grp_seen[g] ||
               (cur_mode == MODE_MIN ? (it.item_value < grp_acc[g])
                                     : (it.item_value > grp_acc[g])))
        grp_acc[g] = it.item_value;
      grp_seen[g] = 1'b1;
      return;
    end
    n_read++;
    r.result_group  = it.group_index;
    r.result_value  = '0;
    r.result_status = ST_VALID;
    if (!cur_skip && grp_miss[g]) begin
      r.result_status = ST_MISSING;
    end else if (cur_mode == MODE_SUM) begin
      r.result_value = grp_acc[g];
      if (grp_acc[g] > 64'sd2147483647 || grp_acc[g] < -64'sd2147483648)
        r.result_status = ST_WIDE;
    end else if (cur_mode == MODE_MEAN) begin
      div = cur_skip ? grp_present[g] : grp_items[g];
      if (grp_present[g] == 0 || div == 0) r.result_status = ST_EMPTY;
      else r.result_value = mean_fixed(grp_acc[g], div);
    end else begin
      if (!grp_seen[g]) r.result_status = ST_EMPTY;
      else r.result_value = grp_acc[g];
    end
    wipe_group(g);
    pending_results.push_back(r);
  endtask

  // Receiver side: random stall at the configured rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  // Check every result taken against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: group %0d value %0d status %0d",
                   out_item.result_group, out_item.result_value, out_item.result_status);
      end else begin
        want = pending_results.pop_front();
        if (out_item.result_group !== want.result_group ||
            out_item.result_value !== want.result_value ||
            out_item.result_status !== want.result_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected g %0d v %0d s %0d, got g %0d v %0d s %0d",
                     want.result_group, want.result_value, want.result_status,
                     out_item.result_group, out_item.result_value,
                     out_item.result_status);
        end
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, hold it until accepted, then predict its effect
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predict_aggregate(it);
  endtask

  function automatic in_item_t make_item(logic op, int g, logic signed [31:0] v, logic m);
    in_item_t it;
    it.op = op; it.group_index = g; it.item_value = v; it.item_missing = m;
    return it;
  endfunction

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx == CFG_MODE) cur_mode = agg_mode_t'(val[1:0]);
    else cur_skip = val[0];
  endtask

  task automatic set_config(agg_mode_t mode, logic skip);
    // upper data bits are don't-care; toggle them anyway
    write_reg(CFG_MODE, {$urandom} & ~32'd3 | mode);
    write_reg(CFG_SKIP, {$urandom} & ~32'd1 | skip);
  endtask

  // Extremes, each mode, missing handling, empty groups, mode change
  task automatic test_directed();
    set_config(MODE_SUM, 1'b0);
    send_item(make_item(OP_ACC, 0, 32'sh7FFF_FFFF, 1'b0));
    send_item(make_item(OP_ACC, 0, 32'sh7FFF_FFFF, 1'b0));
    send_item(make_item(OP_READ, 0, 0, 1'b0));                 // wide sum
    send_item(make_item(OP_ACC, 1023, 32'sh8000_0000, 1'b0));
    send_item(make_item(OP_READ, 1023, 32'sh7FFF_FFFF, 1'b1)); // most negative
    send_item(make_item(OP_READ, 5, 0, 1'b0));                 // empty sum
    send_item(make_item(OP_ACC, 3, 9, 1'b1));
    send_item(make_item(OP_ACC, 3, 4, 1'b0));
    send_item(make_item(OP_READ, 3, 0, 1'b0));                 // missing result
    set_config(MODE_MEAN, 1'b1);
    send_item(make_item(OP_ACC, 7, 1, 1'b0));
    send_item(make_item(OP_ACC, 7, 2, 1'b0));
    send_item(make_item(OP_ACC, 7, -5, 1'b1));
    send_item(make_item(OP_READ, 7, 0, 1'b0));                 // mean skipping missing
    send_item(make_item(OP_READ, 8, 0, 1'b0));                 // mean, no present values
    send_item(make_item(OP_ACC, 9, -7, 1'b0));
    send_item(make_item(OP_ACC, 9, 0, 1'b0));
    send_item(make_item(OP_ACC, 9, 0, 1'b0));
    send_item(make_item(OP_READ, 9, 0, 1'b0));                 // negative mean, truncated
    set_config(MODE_MIN, 1'b0);
    send_item(make_item(OP_ACC, 12, 50, 1'b0));
    send_item(make_item(OP_ACC, 12, -3, 1'b0));
    set_config(MODE_MAX, 1'b0);
    send_item(make_item(OP_ACC, 12, 20, 1'b0));                // mode change mid-group
    send_item(make_item(OP_READ, 12, 0, 1'b0));
    send_item(make_item(OP_READ, 13, 0, 1'b0));                // max, never seen
    wait_idle();
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Mostly accumulate-then-read over a small set of groups; some noise elsewhere
  task automatic test_random(int count);
    int        g;
    logic      op;
    for (int i = 0; i < count; i++) begin
      g  = ($urandom_range(9) == 0) ? $urandom_range(NGROUPS - 1) : $urandom_range(15);
      op = ($urandom_range(99) < 22) ? OP_READ : OP_ACC;
      send_item(make_item(op, g, pick_value(), $urandom_range(99) < 12));
      if (i % 50 == 49)
        set_config(agg_mode_t'($urandom_range(3)), $urandom_range(1));
    end
    // flush the busy groups so each of their records gets read back
    for (int k = 0; k < 16; k++) send_item(make_item(OP_READ, k, $urandom, $urandom_range(1)));
  endtask

  // Hold the sender until the result queue is empty, then resume
  task automatic test_pause();
    for (int i = 0; i < 6; i++) send_item(make_item(OP_ACC, 20, pick_value(), 1'b0));
    send_item(make_item(OP_READ, 20, 0, 1'b0));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    send_item(make_item(OP_READ, 20, 0, 1'b0));
    wait_idle();
  endtask

  initial begin
    for (int g = 0; g < NGROUPS; g++) wipe_group(g);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle = 12; rcv_idle = 55;
    test_directed();
    test_random(120);
    test_pause();
    snd_idle = 55; rcv_idle = 12;
    test_random(110);
    snd_idle = 0; rcv_idle = 0;
    test_random(110);
    set_config(MODE_MEAN, 1'b0);
    test_random(20);
    wait_idle();

    $display("covered %0d accumulates and %0d reads (%0d results checked)",
             n_acc, n_read, n_checked);
    $display("%0d register writes over all modes, with and without missing skip", n_cfg);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: grouped_aggregate_engine_top.f
sv/gae_pkg.sv
sv/gae_datapath.sv
sv/gae_ctrl.sv
sv/grouped_aggregate_engine_top.sv
sv/gae_checker.sv
sim/tb_top.sv
